// ===== rtl/voxel_volume_shape_fill_assert.svh =====
// assertion macros for the voxel volume shape fill block
// used by the port checker; needs clk and rst in the scope of use
`ifndef VOXEL_VOLUME_SHAPE_FILL_ASSERT_SVH
`define VOXEL_VOLUME_SHAPE_FILL_ASSERT_SVH

// same-cycle implication
`define VVSF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vvsf check failed");

// next-cycle implication
`define VVSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vvsf check failed");

`endif

// ===== rtl/vvsf_pkg.sv =====
// shared types, codes and widths for the voxel volume shape fill block
// no dependencies
package vvsf_pkg;

  localparam int DEF_MAX_X  = 32;
  localparam int DEF_MAX_Y  = 32;
  localparam int DEF_MAX_Z  = 32;

  localparam int EXT_W      = 7;
  localparam int COORD_W    = 9;
  localparam int DIFF_W     = 11;
  localparam int MAG_W      = 10;
  localparam int SQ_W       = 17;
  localparam int SUM_W      = 19;
  localparam int PAIR_W     = 34;
  localparam int TRIP_W     = 51;
  localparam int ESUM_W     = 53;
  localparam int CNT_W      = 16;
  localparam int COL_W      = 8;
  localparam int SIZE_W     = 6;
  localparam int WORD_W     = 33;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 56;

  localparam logic [2:0] KIND_VOXEL     = 3'd0;
  localparam logic [2:0] KIND_BOX       = 3'd1;
  localparam logic [2:0] KIND_SPHERE    = 3'd2;
  localparam logic [2:0] KIND_ELLIPSOID = 3'd3;
  localparam logic [2:0] KIND_READ      = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RED    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 3'd6;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP_A,
    ST_PREP_B,
    ST_PREP_C,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic clear_wr;
    logic issue;
    logic single;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_scan;
    logic is_single;
    logic empty;
    logic in_grid;
    logic busy;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/vvsf_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module vvsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/vvsf_dpath.sv =====
// datapath: config registers, command registers, shape test pipeline,
// voxel store, on counter and result register; uses vvsf_pkg and vvsf_ram
module vvsf_dpath
  import vvsf_pkg::*;
#(
  parameter int MAX_X = DEF_MAX_X,
  parameter int MAX_Y = DEF_MAX_Y,
  parameter int MAX_Z = DEF_MAX_Z,
  localparam int XW = (MAX_X > 1) ? $clog2(MAX_X) : 1,
  localparam int YW = (MAX_Y > 1) ? $clog2(MAX_Y) : 1,
  localparam int ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1,
  localparam int DEPTH = MAX_X * MAX_Y * MAX_Z,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic [IN_USER_W-1:0]  in_user,
  input  ctrl_cmd_t             cmd,
  input  logic [AW-1:0]         clr_addr,
  input  logic [XW-1:0]         scan_x,
  input  logic [YW-1:0]         scan_y,
  input  logic [ZW-1:0]         scan_z,
  output dp_status_t            status,
  output logic [EXT_W-1:0]      ext_x,
  output logic [EXT_W-1:0]      ext_y,
  output logic [EXT_W-1:0]      ext_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int YZ = MAX_Y * MAX_Z;

  function automatic logic [SQ_W-1:0] sq_diff(input logic signed [DIFF_W-1:0] d);
    logic [MAG_W-1:0] m;
    m = d[DIFF_W-1] ? MAG_W'(-d) : MAG_W'(d);
    return SQ_W'(m) * SQ_W'(m);
  endfunction

  function automatic logic [SQ_W-1:0] sq_rad(input logic signed [COORD_W-1:0] r);
    logic [COORD_W-1:0] m;
    m = r[COORD_W-1] ? COORD_W'(-r) : COORD_W'(r);
    return SQ_W'(m) * SQ_W'(m);
  endfunction

  logic [SIZE_W-1:0] size_x, size_y, size_z;
  logic [COL_W-1:0]  paint_red, paint_green, paint_blue, paint_alpha;

  logic [2:0]                kind;
  logic                      fill;
  logic signed [COORD_W-1:0] a_x, a_y, a_z, b_x, b_y, b_z;

  logic [SQ_W-1:0]   rx2, ry2, rz2;
  logic [PAIR_W-1:0] p_xy, p_xz, p_yz;
  logic [TRIP_W-1:0] p_xyz;

  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic [ZW-1:0] cz;
  logic [AW-1:0] addr0;
  logic signed [DIFF_W-1:0] ix0, iy0, iz0, dx0, dy0, dz0;
  logic box0;

  logic              s1_valid;
  logic [AW-1:0]     s1_addr;
  logic [SQ_W-1:0]   s1_dx2, s1_dy2, s1_dz2;
  logic              s1_box;

  logic              s2_valid;
  logic [AW-1:0]     s2_addr;
  logic [TRIP_W-1:0] s2_tx, s2_ty, s2_tz;
  logic [SUM_W-1:0]  s2_dsum;
  logic              s2_box;
  logic [WORD_W-1:0] s2_word;

  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] res_word;
  logic [CNT_W-1:0]  on_count;

  logic              sel2;
  logic              wr2;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] wr_word;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x      <= SIZE_W'(32);
      size_y      <= SIZE_W'(32);
      size_z      <= SIZE_W'(32);
      paint_red   <= '0;
      paint_green <= '0;
      paint_blue  <= '0;
      paint_alpha <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIZE_X: size_x      <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Y: size_y      <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Z: size_z      <= cfg_data[SIZE_W-1:0];
        REG_RED:    paint_red   <= cfg_data;
        REG_GREEN:  paint_green <= cfg_data;
        REG_BLUE:   paint_blue  <= cfg_data;
        REG_ALPHA:  paint_alpha <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ext_x = ({1'b0, size_x} < EXT_W'(MAX_X)) ? {1'b0, size_x} : EXT_W'(MAX_X);
  assign ext_y = ({1'b0, size_y} < EXT_W'(MAX_Y)) ? {1'b0, size_y} : EXT_W'(MAX_Y);
  assign ext_z = ({1'b0, size_z} < EXT_W'(MAX_Z)) ? {1'b0, size_z} : EXT_W'(MAX_Z);

  // command capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= in_user[2:0];
      fill <= in_user[3];
      a_x  <= in_data[8:0];
      a_y  <= in_data[17:9];
      a_z  <= in_data[26:18];
      b_x  <= in_data[35:27];
      b_y  <= in_data[44:36];
      b_z  <= in_data[53:45];
    end
  end

  // radius products, settled during the prep cycles
  always_ff @(posedge clk) begin
    rx2   <= sq_rad(b_x);
    ry2   <= sq_rad(b_y);
    rz2   <= sq_rad(b_z);
    p_xy  <= PAIR_W'(rx2) * PAIR_W'(ry2);
    p_xz  <= PAIR_W'(rx2) * PAIR_W'(rz2);
    p_yz  <= PAIR_W'(ry2) * PAIR_W'(rz2);
    p_xyz <= TRIP_W'(p_xy) * TRIP_W'(rz2);
  end

  assign status.is_scan   = (kind == KIND_BOX) || (kind == KIND_SPHERE) ||
                            (kind == KIND_ELLIPSOID);
  assign status.is_single = (kind == KIND_VOXEL) || (kind == KIND_READ);
  assign status.empty     = (ext_x == '0) || (ext_y == '0) || (ext_z == '0);
  assign status.in_grid   = !a_x[COORD_W-1] && ({1'b0, a_x[7:0]} < {2'b0, ext_x}) &&
                            !a_y[COORD_W-1] && ({1'b0, a_y[7:0]} < {2'b0, ext_y}) &&
                            !a_z[COORD_W-1] && ({1'b0, a_z[7:0]} < {2'b0, ext_z});
  assign status.busy      = s1_valid || s2_valid;
  assign status.out_free  = !out_valid || out_ready;

  // stage 0: coordinates, address, differences, box test
  assign cx = cmd.single ? XW'(a_x[7:0]) : scan_x;
  assign cy = cmd.single ? YW'(a_y[7:0]) : scan_y;
  assign cz = cmd.single ? ZW'(a_z[7:0]) : scan_z;

  assign addr0 = AW'(cx) * AW'(YZ) + AW'(cy) * AW'(MAX_Z) + AW'(cz);

  assign ix0 = $signed({{(DIFF_W-XW){1'b0}}, cx});
  assign iy0 = $signed({{(DIFF_W-YW){1'b0}}, cy});
  assign iz0 = $signed({{(DIFF_W-ZW){1'b0}}, cz});
  assign dx0 = ix0 - DIFF_W'(a_x);
  assign dy0 = iy0 - DIFF_W'(a_y);
  assign dz0 = iz0 - DIFF_W'(a_z);

  assign box0 = !dx0[DIFF_W-1] && (ix0 <= DIFF_W'(b_x)) &&
                !dy0[DIFF_W-1] && (iy0 <= DIFF_W'(b_y)) &&
                !dz0[DIFF_W-1] && (iz0 <= DIFF_W'(b_z));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= addr0;
    s1_dx2  <= sq_diff(dx0);
    s1_dy2  <= sq_diff(dy0);
    s1_dz2  <= sq_diff(dz0);
    s1_box  <= box0;
    s2_addr <= s1_addr;
    s2_tx   <= TRIP_W'(s1_dx2) * TRIP_W'(p_yz);
    s2_ty   <= TRIP_W'(s1_dy2) * TRIP_W'(p_xz);
    s2_tz   <= TRIP_W'(s1_dz2) * TRIP_W'(p_xy);
    s2_dsum <= SUM_W'(s1_dx2) + SUM_W'(s1_dy2) + SUM_W'(s1_dz2);
    s2_box  <= s1_box;
    s2_word <= rd_word;
  end

  // stage 2: selection and write back
  always_comb begin
    unique case (kind)
      KIND_BOX:       sel2 = s2_box;
      KIND_SPHERE:    sel2 = s2_dsum <= SUM_W'(rx2);
      KIND_ELLIPSOID: sel2 = (rx2 != '0) && (ry2 != '0) && (rz2 != '0) &&
                             ((ESUM_W'(s2_tx) + ESUM_W'(s2_ty) + ESUM_W'(s2_tz)) <=
                              ESUM_W'(p_xyz));
      default:        sel2 = 1'b1;
    endcase
  end

  assign wr2     = s2_valid && sel2 && (kind != KIND_READ);
  assign wr_word = fill ? {1'b1, paint_alpha, paint_blue, paint_green, paint_red}
                        : {1'b0, s2_word[WORD_W-2:0]};

  assign ram_we    = cmd.clear_wr || wr2;
  assign ram_waddr = cmd.clear_wr ? clr_addr : s2_addr;
  assign ram_wdata = cmd.clear_wr ? '0 : wr_word;

  vvsf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.issue),
    .raddr (addr0),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      on_count <= '0;
    end else if (wr2) begin
      if (fill && !s2_word[WORD_W-1]) begin
        on_count <= on_count + CNT_W'(1);
      end else if (!fill && s2_word[WORD_W-1]) begin
        on_count <= on_count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_word <= '0;
    end else if (s2_valid && (kind == KIND_READ)) begin
      res_word <= s2_word;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= {7'b0, on_count, res_word[WORD_W-2:0], res_word[WORD_W-1]};
    end
  end

endmodule

// ===== rtl/vvsf_ctrl.sv =====
// controller: clearing pass, command sequencing and grid scan counters
// uses vvsf_pkg
module vvsf_ctrl
  import vvsf_pkg::*;
#(
  parameter int MAX_X = DEF_MAX_X,
  parameter int MAX_Y = DEF_MAX_Y,
  parameter int MAX_Z = DEF_MAX_Z,
  localparam int XW = (MAX_X > 1) ? $clog2(MAX_X) : 1,
  localparam int YW = (MAX_Y > 1) ? $clog2(MAX_Y) : 1,
  localparam int ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1,
  localparam int DEPTH = MAX_X * MAX_Y * MAX_Z,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  dp_status_t       status,
  input  logic [EXT_W-1:0] ext_x,
  input  logic [EXT_W-1:0] ext_y,
  input  logic [EXT_W-1:0] ext_z,
  output ctrl_cmd_t        cmd,
  output logic [AW-1:0]    clr_addr,
  output logic [XW-1:0]    scan_x,
  output logic [YW-1:0]    scan_y,
  output logic [ZW-1:0]    scan_z
);

  state_t state, state_next;
  logic   last_x, last_y, last_z;

  assign last_x = (EXT_W'(scan_x) + EXT_W'(1)) == ext_x;
  assign last_y = (EXT_W'(scan_y) + EXT_W'(1)) == ext_y;
  assign last_z = (EXT_W'(scan_z) + EXT_W'(1)) == ext_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      scan_x <= '0;
      scan_y <= '0;
      scan_z <= '0;
    end else if (state == ST_SCAN) begin
      if (!last_z) begin
        scan_z <= scan_z + ZW'(1);
      end else begin
        scan_z <= '0;
        if (!last_y) begin
          scan_y <= scan_y + YW'(1);
        end else begin
          scan_y <= '0;
          scan_x <= scan_x + XW'(1);
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_PREP_A;
        end
      end
      ST_PREP_A: state_next = ST_PREP_B;
      ST_PREP_B: state_next = ST_PREP_C;
      ST_PREP_C: begin
        priority if (status.is_single && status.in_grid) begin
          cmd.issue  = 1'b1;
          cmd.single = 1'b1;
          state_next = ST_DRAIN;
        end else if (status.is_scan && !status.empty) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (last_x && last_y && last_z) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

// ===== rtl/voxel_volume_shape_fill.sv =====
// voxel volume shape fill, top level
// uses vvsf_pkg, vvsf_ctrl, vvsf_dpath (with vvsf_ram)
//
// usage:
// - s_axis takes one command item: tuser holds kind and fill, tdata the
//   first and second corner or centre and radius fields
// - m_axis returns one result item per command: read voxel data and the
//   running on count
// - cfg_we, cfg_index, cfg_data write grid size and paint colour while idle
// - after reset the store is cleared one entry a cycle, all MAX_X*MAX_Y*MAX_Z
//   entries (32768 at default size); s_axis_tready stays low meanwhile
// - one command at a time: the prep states settle the radius products, then
//   shapes scan the ex*ey*ez grid, one voxel a cycle through the store's
//   read and write ports, then the pipeline drains and the result is registered
// - single voxel and read commands issue one voxel with no scan, unused kinds none
// - a new command is taken while the last result waits; if the receiver
//   stalls, the next result holds the block until the register frees
module voxel_volume_shape_fill
  import vvsf_pkg::*;
#(
  parameter int MAX_X = DEF_MAX_X,
  parameter int MAX_Y = DEF_MAX_Y,
  parameter int MAX_Z = DEF_MAX_Z
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind, fill
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // voxel_on, voxel_red, voxel_green, voxel_blue, voxel_alpha, on_total, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int XW = (MAX_X > 1) ? $clog2(MAX_X) : 1;
  localparam int YW = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
  localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ctrl_cmd_t        cmd;
  dp_status_t       status;
  logic [AW-1:0]    clr_addr;
  logic [XW-1:0]    scan_x;
  logic [YW-1:0]    scan_y;
  logic [ZW-1:0]    scan_z;
  logic [EXT_W-1:0] ext_x, ext_y, ext_z;

  vvsf_ctrl #(
    .MAX_X (MAX_X),
    .MAX_Y (MAX_Y),
    .MAX_Z (MAX_Z)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .ext_x    (ext_x),
    .ext_y    (ext_y),
    .ext_z    (ext_z),
    .cmd      (cmd),
    .clr_addr (clr_addr),
    .scan_x   (scan_x),
    .scan_y   (scan_y),
    .scan_z   (scan_z)
  );

  vvsf_dpath #(
    .MAX_X (MAX_X),
    .MAX_Y (MAX_Y),
    .MAX_Z (MAX_Z)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cmd       (cmd),
    .clr_addr  (clr_addr),
    .scan_x    (scan_x),
    .scan_y    (scan_y),
    .scan_z    (scan_z),
    .status    (status),
    .ext_x     (ext_x),
    .ext_y     (ext_y),
    .ext_z     (ext_z),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// ===== rtl/vvsf_checker.sv =====
// port checker for voxel_volume_shape_fill, bound to the top level
// uses vvsf_pkg and voxel_volume_shape_fill_assert.svh
`include "voxel_volume_shape_fill_assert.svh"

module vvsf_checker
  import vvsf_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // stalled result holds
  `VVSF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata))

  // one command at a time
  `VVSF_ASSERT_NEXT(a_one_cmd, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // a fresh result only comes out of a busy cycle
  `VVSF_ASSERT_SAME(a_res_after_work, $rose(m_axis_tvalid), $past(!s_axis_tready))

endmodule

bind voxel_volume_shape_fill vvsf_checker u_vvsf_checker (.*);

// ===== tb/voxel_volume_shape_fill_checker.sv =====
`timescale 1ns / 100ps
// result checker for the voxel volume shape fill block: watches the config port and both
// item channels, keeps its own voxel store and compares every result item in order
// depends on vvsf_pkg
module voxel_volume_shape_fill_checker
  import vvsf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [IN_USER_W-1:0]  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  output int                    errors,
  output int                    pending,
  output int                    commands_seen
);

  localparam int CELLS = DEF_MAX_X * DEF_MAX_Y * DEF_MAX_Z;

  typedef struct packed {
    logic            lit;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [7:0]      alpha;
    logic [CNT_W-1:0] total;
  } voxel_result_t;

  bit              cell_lit [CELLS];
  bit [31:0]       cell_rgba [CELLS];
  int              lit_count;
  bit [SIZE_W-1:0] grid_x, grid_y, grid_z;
  bit [31:0]       paint_rgba;
  voxel_result_t   expected_results [$];

  assign pending = expected_results.size();

  function automatic longint sq(longint d);
    return d * d;
  endfunction

  function automatic void paint_cell(int idx, bit put);
    if (put) begin
      if (!cell_lit[idx]) lit_count++;
      cell_lit[idx] = 1'b1;
      cell_rgba[idx] = paint_rgba;
    end else begin
      if (cell_lit[idx]) lit_count--;
      cell_lit[idx] = 1'b0;
    end
  endfunction

  function automatic bit shape_hit(logic [2:0] kind, int i, int j, int k, int a[3], int b[3]);
    longint rx2, ry2, rz2;
    rx2 = sq(b[0]);
    ry2 = sq(b[1]);
    rz2 = sq(b[2]);
    if (kind == KIND_BOX)
      return i >= a[0] && i <= b[0] && j >= a[1] && j <= b[1] && k >= a[2] && k <= b[2];
    if (kind == KIND_SPHERE)
      return sq(i - a[0]) + sq(j - a[1]) + sq(k - a[2]) <= rx2;
    if (rx2 == 0 || ry2 == 0 || rz2 == 0) return 1'b0;
    return sq(i - a[0]) * ry2 * rz2 + sq(j - a[1]) * rx2 * rz2 + sq(k - a[2]) * rx2 * ry2
           <= rx2 * ry2 * rz2;
  endfunction

  function automatic voxel_result_t run_command(logic [2:0] kind, bit put,
                                                logic [IN_DATA_W-1:0] data);
    voxel_result_t res;
    int a[3], b[3];
    int ex, ey, ez, idx;
    res = '0;
    for (int n = 0; n < 3; n++) begin
      a[n] = int'($signed(data[9*n +: 9]));
      b[n] = int'($signed(data[27 + 9*n +: 9]));
    end
    ex = grid_x < DEF_MAX_X ? grid_x : DEF_MAX_X;
    ey = grid_y < DEF_MAX_Y ? grid_y : DEF_MAX_Y;
    ez = grid_z < DEF_MAX_Z ? grid_z : DEF_MAX_Z;
    if (kind == KIND_VOXEL || kind == KIND_READ) begin
      if (a[0] >= 0 && a[0] < ex && a[1] >= 0 && a[1] < ey && a[2] >= 0 && a[2] < ez) begin
        idx = (a[0] * DEF_MAX_Y + a[1]) * DEF_MAX_Z + a[2];
        if (kind == KIND_VOXEL) begin
          paint_cell(idx, put);
        end else begin
          res.lit   = cell_lit[idx];
          res.red   = cell_rgba[idx][7:0];
          res.green = cell_rgba[idx][15:8];
          res.blue  = cell_rgba[idx][23:16];
          res.alpha = cell_rgba[idx][31:24];
        end
      end
    end else if (kind == KIND_BOX || kind == KIND_SPHERE || kind == KIND_ELLIPSOID) begin
      for (int i = 0; i < ex; i++)
        for (int j = 0; j < ey; j++)
          for (int k = 0; k < ez; k++)
            if (shape_hit(kind, i, j, k, a, b))
              paint_cell((i * DEF_MAX_Y + j) * DEF_MAX_Z + k, put);
    end
    res.total = lit_count[CNT_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    voxel_result_t want, got;
    if (rst) begin
      for (int n = 0; n < CELLS; n++) begin
        cell_lit[n] = 1'b0;
        cell_rgba[n] = '0;
      end
      lit_count = 0;
      grid_x = 6'd32;
      grid_y = 6'd32;
      grid_z = 6'd32;
      paint_rgba = '0;
      expected_results.delete();
      errors = 0;
      commands_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SIZE_X: grid_x = cfg_data[SIZE_W-1:0];
          REG_SIZE_Y: grid_y = cfg_data[SIZE_W-1:0];
          REG_SIZE_Z: grid_z = cfg_data[SIZE_W-1:0];
          REG_RED:    paint_rgba[7:0] = cfg_data;
          REG_GREEN:  paint_rgba[15:8] = cfg_data;
          REG_BLUE:   paint_rgba[23:16] = cfg_data;
          REG_ALPHA:  paint_rgba[31:24] = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        expected_results.push_back(run_command(s_tuser[2:0], s_tuser[3], s_tdata));
        commands_seen++;
      end
      if (m_tvalid && m_tready) begin
        got.lit   = m_tdata[0];
        got.red   = m_tdata[8:1];
        got.green = m_tdata[16:9];
        got.blue  = m_tdata[24:17];
        got.alpha = m_tdata[32:25];
        got.total = m_tdata[48:33];
        if (expected_results.size() == 0) begin
          $display("%0t: result item with nothing expected: %h", $time, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.lit !== want.lit)
            $display("%0t: voxel_on expected %0d got %0d", $time, want.lit, got.lit);
          if (got.red !== want.red)
            $display("%0t: voxel_red expected %0d got %0d", $time, want.red, got.red);
          if (got.green !== want.green)
            $display("%0t: voxel_green expected %0d got %0d", $time, want.green, got.green);
          if (got.blue !== want.blue)
            $display("%0t: voxel_blue expected %0d got %0d", $time, want.blue, got.blue);
          if (got.alpha !== want.alpha)
            $display("%0t: voxel_alpha expected %0d got %0d", $time, want.alpha, got.alpha);
          if (got.total !== want.total)
            $display("%0t: on_total expected %0d got %0d", $time, want.total, got.total);
          if (got !== want) errors++;
        end
      end
    end
  end

endmodule

// ===== tb/voxel_volume_shape_fill_tb.sv =====
`timescale 1ns / 100ps
// testbench top for voxel_volume_shape_fill: directed and random shape, voxel and read
// commands over several grid sizes and paint colours; depends on vvsf_pkg and the checker
module voxel_volume_shape_fill_tb;
  import vvsf_pkg::*;

  localparam int IDLE_LIMIT = 200000;
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int errors, pending, commands_seen;
  int settings_used = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit no_gaps = 1'b0;
  bit sink_always_ready = 1'b0;
  int ext_x, ext_y, ext_z;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  voxel_volume_shape_fill dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  voxel_volume_shape_fill_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
    .s_tdata(s_axis_tdata), .s_tuser(s_axis_tuser),
    .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready), .m_tdata(m_axis_tdata),
    .errors(errors), .pending(pending), .commands_seen(commands_seen)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!sink_always_ready) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic set_regs(int sx, int sy, int sz, int red, int green, int blue, int alpha);
    int vals[7];
    vals = '{sx, sy, sz, red, green, blue, alpha};
    for (int n = 0; n < 7; n++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(n);
      cfg_data <= CFG_DATA_W'(vals[n]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    ext_x = sx;
    ext_y = sy;
    ext_z = sz;
    settings_used++;
    no_gaps = ($urandom_range(0, 3) == 0);
    sink_always_ready = ($urandom_range(0, 3) == 0);
  endtask

  task automatic send(logic [2:0] kind, bit fill, int fx, int fy, int fz,
                      int sx, int sy, int sz);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= {fill, kind};
    s_axis_tdata <= {2'b00, 9'(sz), 9'(sy), 9'(sx), 9'(fz), 9'(fy), 9'(fx)};
    do @(posedge clk); while (!s_axis_tready);
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender holds off until every result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic int near(int ext);
    return $urandom_range(0, ext + 3) - 2;
  endfunction

  task automatic random_command();
    logic [2:0] kind;
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      send(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
           $urandom_range(0, 511) - 256, $urandom_range(0, 511) - 256,
           $urandom_range(0, 511) - 256, $urandom_range(0, 511) - 256,
           $urandom_range(0, 511) - 256, $urandom_range(0, 511) - 256);
    end else begin
      kind = 3'($urandom_range(0, 4));
      if (kind == KIND_BOX)
        send(kind, $urandom_range(0, 3) != 0, near(ext_x), near(ext_y), near(ext_z),
             near(ext_x), near(ext_y), near(ext_z));
      else if (kind == KIND_SPHERE || kind == KIND_ELLIPSOID)
        send(kind, $urandom_range(0, 3) != 0, near(ext_x), near(ext_y), near(ext_z),
             $urandom_range(0, ext_x + 1) * ($urandom_range(0, 4) == 0 ? -1 : 1),
             $urandom_range(0, ext_y + 1), $urandom_range(0, ext_z + 1));
      else
        send(kind, 1'($urandom_range(0, 1)), near(ext_x), near(ext_y), near(ext_z),
             $urandom_range(0, 511) - 256, $urandom_range(0, 511) - 256,
             $urandom_range(0, 511) - 256);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_regs(4, 5, 6, 255, 0, 170, 85);
    send(KIND_READ, 1'b0, 0, 0, 0, 0, 0, 0);
    send(KIND_VOXEL, 1'b1, 0, 0, 0, 0, 0, 0);
    send(KIND_VOXEL, 1'b1, 3, 4, 5, 0, 0, 0);
    send(KIND_VOXEL, 1'b1, -1, 0, 0, 0, 0, 0);
    send(KIND_VOXEL, 1'b1, 4, 0, 0, 0, 0, 0);
    send(KIND_READ, 1'b1, 3, 4, 5, 0, 0, 0);
    send(KIND_READ, 1'b0, 0, 5, 0, 0, 0, 0);
    send(KIND_VOXEL, 1'b0, 3, 4, 5, 0, 0, 0);
    send(KIND_READ, 1'b0, 3, 4, 5, 0, 0, 0);
    send(KIND_BOX, 1'b1, -256, -256, -256, 255, 255, 255);
    send(KIND_BOX, 1'b0, 2, 0, 0, 1, 4, 5);
    send(KIND_BOX, 1'b0, 1, 1, 1, 2, 3, 4);
    send(KIND_SPHERE, 1'b0, 2, 2, 2, 0, 0, 0);
    send(KIND_SPHERE, 1'b0, 0, 0, 0, -2, 0, 0);
    send(KIND_READ, 1'b0, 2, 2, 2, 0, 0, 0);
    send(KIND_ELLIPSOID, 1'b0, 1, 1, 1, 3, 0, 2);
    send(KIND_ELLIPSOID, 1'b0, 2, 2, 3, -2, 1, -3);
    send(KIND_SPHERE, 1'b0, 255, 255, 255, -256, 0, 0);
    send(KIND_SPARE_LO, 1'b1, 0, 0, 0, 3, 3, 3);
    send(KIND_SPARE_HI, 1'b0, 0, 0, 0, 3, 3, 3);
    send(KIND_READ, 1'b1, 1, 1, 1, 0, 0, 0);
    drain();

    set_regs(32, 32, 32, 17, 34, 51, 255);
    send(KIND_BOX, 1'b1, 0, 0, 0, 31, 31, 31);
    send(KIND_READ, 1'b0, 31, 31, 31, 0, 0, 0);
    send(KIND_ELLIPSOID, 1'b0, 16, 16, 16, 15, 8, 12);
    send(KIND_READ, 1'b0, 16, 16, 16, 0, 0, 0);
    drain();

    set_regs(1, 1, 1, 0, 255, 0, 0);
    repeat (10) random_command();
    drain();

    for (int p = 0; p < 4; p++) begin
      set_regs($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8),
               $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(0, 255));
      repeat (23) random_command();
      drain();
    end

    $display("ran %0d commands through %0d grid and paint settings", commands_seen,
             settings_used);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
